>>> hdl/bb3_pkg.sv
// Shared types, constants and helper functions for the edge-aware 3x3 box blur.
package bb3_pkg;

    localparam int PIX_BITS      = 8;
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_EXT_BITS  = 14;
    localparam int CFG_DATA_BITS = 13;
    localparam int ROW_BITS      = 12;
    localparam int SUM_BITS      = 12;
    localparam int CNT_BITS      = 4;
    localparam int NUM_BITS      = 13;
    localparam int RECIP_BITS    = 18;
    localparam int RECIP_SHIFT   = 18;
    localparam int PROD_BITS     = NUM_BITS + RECIP_BITS;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] red;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] blue;
    } pixel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PX_RD,
        ST_PX_WB,
        ST_DR_RM,
        ST_DR_RC,
        ST_DR_RP,
        ST_DR_LD,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_COL,
        RD_DM1,
        RD_D0,
        RD_DP1
    } rd_sel_t;

    typedef struct packed {
        logic    px_take;
        logic    px_wb;
        logic    dr_shift;
        logic    dr_setup;
        logic    sum_load;
        logic    mul_load;
        logic    out_load;
        logic    next_res;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic frame_complete;
        logic emit_now;
        logic second_pending;
        logic out_free;
    } status_t;

    // Reciprocal of twice the neighbor count, scaled by 2^RECIP_SHIFT and rounded up.
    function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] count);
        logic [RECIP_BITS-1:0] m;
        begin
            case (count)
                4'd1:    m = 18'd131072;
                4'd2:    m = 18'd65536;
                4'd3:    m = 18'd43691;
                4'd4:    m = 18'd32768;
                4'd6:    m = 18'd21846;
                4'd9:    m = 18'd14564;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

endpackage

>>> hdl/box_blur_3x3_edge_aware.sv
// Top level of the edge-aware 3x3 box blur for RGB pixel streams.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata pixel, s_tuser drain flag
// m_*      out  m_tvalid/m_tready  m_tdata averages, m_tlast final pixel of the image
// cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// Pixels read and write back, drains read three columns, load; results sum, multiply, emit.
// Each pixel costs one line-store read and one write-back.
// The three columns of a drain window are read from the line store one per cycle.
// Reset clears counters and control; the line store is not cleared.
// A result waits in the output register while the next request is taken; m_tready low
// holds the controller only when a further result is ready to load.
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [3*bb3_pkg::PIX_BITS-1:0]    s_tdata,   // red_in, green_in, blue_in
    input  logic                              s_tuser,   // drain
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [3*bb3_pkg::PIX_BITS-1:0]    m_tdata,   // red_out, green_out, blue_out
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    bb3_pkg::cmd_t    cmd;
    bb3_pkg::status_t status;

    assign cfg_ready = 1'b1;

    bb3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_drain (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bb3_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> hdl/bb3_ram.sv
// Generic single-port-write, registered-read memory.
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bb3_ctrl.sv
// Controller state machine sequencing pixel, drain and result steps.
module bb3_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_drain,
    output logic             in_ready,
    input  bb3_pkg::status_t status,
    output bb3_pkg::cmd_t    cmd
);

    bb3_pkg::state_t state_reg;
    bb3_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bb3_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bb3_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.frame_complete && in_drain)
                    begin
                        state_next = bb3_pkg::ST_DR_RM;
                    end
                    else if (!status.frame_complete && !in_drain)
                    begin
                        state_next = bb3_pkg::ST_PX_RD;
                    end
                end
            end
            bb3_pkg::ST_PX_RD: state_next = bb3_pkg::ST_PX_WB;
            bb3_pkg::ST_PX_WB:
            begin
                state_next = status.emit_now ? bb3_pkg::ST_SUM : bb3_pkg::ST_IDLE;
            end
            bb3_pkg::ST_DR_RM: state_next = bb3_pkg::ST_DR_RC;
            bb3_pkg::ST_DR_RC: state_next = bb3_pkg::ST_DR_RP;
            bb3_pkg::ST_DR_RP: state_next = bb3_pkg::ST_DR_LD;
            bb3_pkg::ST_DR_LD: state_next = bb3_pkg::ST_SUM;
            bb3_pkg::ST_SUM:   state_next = bb3_pkg::ST_MUL;
            bb3_pkg::ST_MUL:   state_next = bb3_pkg::ST_OUT;
            bb3_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = status.second_pending ? bb3_pkg::ST_SUM : bb3_pkg::ST_IDLE;
                end
            end
            default: state_next = bb3_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.rd_sel = bb3_pkg::RD_COL;
        in_ready = 1'b0;
        unique case (state_reg)
            bb3_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.px_take = in_valid;
            end
            bb3_pkg::ST_PX_RD: cmd.rd_sel = bb3_pkg::RD_COL;
            bb3_pkg::ST_PX_WB: cmd.px_wb = 1'b1;
            bb3_pkg::ST_DR_RM: cmd.rd_sel = bb3_pkg::RD_DM1;
            bb3_pkg::ST_DR_RC:
            begin
                cmd.rd_sel   = bb3_pkg::RD_D0;
                cmd.dr_shift = 1'b1;
            end
            bb3_pkg::ST_DR_RP:
            begin
                cmd.rd_sel   = bb3_pkg::RD_DP1;
                cmd.dr_shift = 1'b1;
            end
            bb3_pkg::ST_DR_LD:
            begin
                cmd.dr_shift = 1'b1;
                cmd.dr_setup = 1'b1;
            end
            bb3_pkg::ST_SUM: cmd.sum_load = 1'b1;
            bb3_pkg::ST_MUL: cmd.mul_load = 1'b1;
            bb3_pkg::ST_OUT:
            begin
                cmd.out_load = status.out_free;
                cmd.next_res = status.out_free && status.second_pending;
            end
            default: cmd = '0;
        endcase
    end

endmodule

>>> hdl/bb3_dp.sv
// Datapath: configuration, counters, line store, 3x3 window, averaging and output register.
module bb3_dp #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [3*bb3_pkg::PIX_BITS-1:0]    in_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [3*bb3_pkg::PIX_BITS-1:0]    m_tdata,
    output logic                              m_tlast,
    input  bb3_pkg::cmd_t                     cmd,
    output bb3_pkg::status_t                  status
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EXT  = bb3_pkg::CFG_EXT_BITS;
    localparam int PB   = 3 * bb3_pkg::PIX_BITS;
    localparam int HB   = bb3_pkg::CFG_H_BITS;
    localparam int SB   = bb3_pkg::SUM_BITS;
    localparam int CB   = bb3_pkg::CNT_BITS;
    localparam int NB   = bb3_pkg::NUM_BITS;
    localparam int QB   = bb3_pkg::PROD_BITS;
    localparam int QL   = bb3_pkg::RECIP_SHIFT;
    localparam int QH   = bb3_pkg::RECIP_SHIFT + bb3_pkg::PIX_BITS - 1;

    logic [bb3_pkg::CFG_W_BITS-1:0] width_reg;
    logic [HB-1:0]                  height_reg;
    logic [WW-1:0]                  eff_w;
    logic [HB-1:0]                  eff_h;
    logic [EXT-1:0]                 w_ext;

    logic [bb3_pkg::ROW_BITS-1:0]   row_reg;
    logic [WW-1:0]                  col_reg;
    logic [WW-1:0]                  drain_reg;
    logic                           fc_reg;
    logic [2:0]                     res_cm_reg;
    logic [2:0]                     res_rm_reg;
    logic                           res_last_reg;
    logic                           second_reg;
    logic                           m_valid_reg;

    bb3_pkg::pixel_t                pix_reg;
    bb3_pkg::pixel_t                win_reg [3][3];
    bb3_pkg::pixel_t                new_col [3];

    logic [SB-1:0]                  sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SB-1:0]                  sum_r, sum_g, sum_b;
    logic [CB-1:0]                  cnt_reg, cnt;
    logic [QB-1:0]                  prod_r_reg, prod_g_reg, prod_b_reg;
    logic [NB-1:0]                  num_r, num_g, num_b;
    logic [bb3_pkg::RECIP_BITS-1:0] rcp;
    logic [bb3_pkg::PIX_BITS-1:0]   red_out_reg, green_out_reg, blue_out_reg;
    logic                           last_out_reg;

    logic                           c_last;
    logic                           r_last;
    logic                           d_last;
    logic [WW-1:0]                  drain_m1;
    logic [WW-1:0]                  drain_p1;
    logic [AW-1:0]                  raddr;
    logic [2*PB-1:0]                rdata;
    logic [2*PB-1:0]                wdata;
    logic [PB-1:0]                  rd_lo, rd_hi;
    logic                           top_slot;

    always_comb
    begin
        w_ext = EXT'(width_reg);
        if (w_ext == '0)
        begin
            eff_w = WW'(1);
        end
        else if (w_ext > EXT'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(w_ext);
        end
        if (height_reg == '0)
        begin
            eff_h = HB'(1);
        end
        else if (height_reg > HB'(bb3_pkg::MAX_HEIGHT))
        begin
            eff_h = HB'(bb3_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign c_last   = (col_reg == eff_w - WW'(1));
    assign r_last   = ((HB'(row_reg) + HB'(1)) >= eff_h);
    assign d_last   = (drain_reg == eff_w - WW'(1));
    assign drain_m1 = drain_reg - WW'(1);
    assign drain_p1 = drain_reg + WW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            bb3_pkg::RD_COL: raddr = col_reg[AW-1:0];
            bb3_pkg::RD_DM1: raddr = drain_m1[AW-1:0];
            bb3_pkg::RD_D0:  raddr = drain_reg[AW-1:0];
            bb3_pkg::RD_DP1: raddr = drain_p1[AW-1:0];
            default:         raddr = col_reg[AW-1:0];
        endcase
    end

    assign rd_lo    = rdata[PB-1:0];
    assign rd_hi    = rdata[2*PB-1:PB];
    assign wdata    = row_reg[0] ? {pix_reg, rd_lo} : {rd_hi, pix_reg};
    assign top_slot = cmd.dr_shift ? eff_h[0] : row_reg[0];

    always_comb
    begin
        new_col[0] = top_slot ? rd_hi : rd_lo;
        new_col[1] = top_slot ? rd_lo : rd_hi;
        new_col[2] = cmd.dr_shift ? '0 : pix_reg;
    end

    bb3_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (cmd.px_wb),
        .waddr (col_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= bb3_pkg::CFG_W_BITS'(bb3_pkg::RESET_WIDTH);
            height_reg   <= HB'(bb3_pkg::RESET_HEIGHT);
            row_reg      <= '0;
            col_reg      <= '0;
            drain_reg    <= '0;
            fc_reg       <= 1'b0;
            res_cm_reg   <= '0;
            res_rm_reg   <= '0;
            res_last_reg <= 1'b0;
            second_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.px_wb)
            begin
                res_cm_reg   <= (col_reg != '0) ? {2'b11, col_reg >= WW'(2)}
                                                : {1'b1, 1'b0, 1'b0};
                res_rm_reg   <= {2'b11, row_reg >= bb3_pkg::ROW_BITS'(2)};
                res_last_reg <= 1'b0;
                second_reg   <= (col_reg != '0) && c_last && (row_reg != '0);
                if (c_last)
                begin
                    col_reg <= '0;
                    if (r_last)
                    begin
                        fc_reg    <= 1'b1;
                        drain_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + bb3_pkg::ROW_BITS'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + WW'(1);
                end
            end
            if (cmd.dr_setup)
            begin
                res_cm_reg   <= {!d_last, 1'b1, drain_reg != '0};
                res_rm_reg   <= {1'b0, 1'b1, eff_h >= HB'(2)};
                res_last_reg <= d_last;
                second_reg   <= 1'b0;
                if (d_last)
                begin
                    row_reg   <= '0;
                    col_reg   <= '0;
                    drain_reg <= '0;
                    fc_reg    <= 1'b0;
                end
                else
                begin
                    drain_reg <= drain_p1;
                end
            end
            if (cmd.next_res)
            begin
                res_cm_reg <= 3'b110;
                second_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    bb3_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[bb3_pkg::CFG_W_BITS-1:0];
                    bb3_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HB-1:0];
                    default:                   width_reg  <= width_reg;
                endcase
                row_reg   <= '0;
                col_reg   <= '0;
                drain_reg <= '0;
                fc_reg    <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        cnt   = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (res_cm_reg[k] && res_rm_reg[j])
                begin
                    sum_r = sum_r + SB'(win_reg[k][j].red);
                    sum_g = sum_g + SB'(win_reg[k][j].green);
                    sum_b = sum_b + SB'(win_reg[k][j].blue);
                    cnt   = cnt + CB'(1);
                end
            end
        end
    end

    assign rcp   = bb3_pkg::recip(cnt_reg);
    assign num_r = {sum_r_reg, 1'b0} + NB'(cnt_reg);
    assign num_g = {sum_g_reg, 1'b0} + NB'(cnt_reg);
    assign num_b = {sum_b_reg, 1'b0} + NB'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.px_take)
        begin
            pix_reg.red   <= in_data[7:0];
            pix_reg.green <= in_data[15:8];
            pix_reg.blue  <= in_data[23:16];
        end
        if (cmd.px_wb || cmd.dr_shift)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win_reg[0][j] <= win_reg[1][j];
                win_reg[1][j] <= win_reg[2][j];
                win_reg[2][j] <= new_col[j];
            end
        end
        if (cmd.sum_load)
        begin
            sum_r_reg <= sum_r;
            sum_g_reg <= sum_g;
            sum_b_reg <= sum_b;
            cnt_reg   <= cnt;
        end
        if (cmd.mul_load)
        begin
            prod_r_reg <= QB'(num_r) * QB'(rcp);
            prod_g_reg <= QB'(num_g) * QB'(rcp);
            prod_b_reg <= QB'(num_b) * QB'(rcp);
        end
        if (cmd.out_load)
        begin
            red_out_reg   <= prod_r_reg[QH:QL];
            green_out_reg <= prod_g_reg[QH:QL];
            blue_out_reg  <= prod_b_reg[QH:QL];
            last_out_reg  <= res_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {blue_out_reg, green_out_reg, red_out_reg};
    assign m_tlast  = last_out_reg;

    assign status.frame_complete = fc_reg;
    assign status.emit_now       = (row_reg != '0) && ((col_reg != '0) || c_last);
    assign status.second_pending = second_reg;
    assign status.out_free       = !m_valid_reg || m_tready;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < eff_w)
        else $error("column position beyond image width");

    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg < eff_w)
        else $error("drain position beyond image width");

    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fc_reg |-> (drain_reg == '0))
        else $error("drain position moved while the image is still open");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && m_valid_reg) |-> m_tready)
        else $error("output register overwritten before it was taken");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && res_last_reg) |-> !fc_reg)
        else $error("final result issued while the image is still marked complete");

endmodule
